/* rtl/core/mapt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving-average peak tracker package
// Widths, limits and the request/response records of the divider.
// ----------------------------------------------------------------------------
package mapt_pkg;

   localparam int SAMPLE_BITS   = 16;
   localparam int MAX_WINDOW    = 64;
   localparam int POS_BITS      = $clog2(MAX_WINDOW);
   localparam int LEN_BITS      = 7;
   localparam int CNT_BITS      = $clog2(MAX_WINDOW + 1);
   localparam int SUM_BITS      = SAMPLE_BITS + POS_BITS;
   localparam int PEAK_BITS     = SAMPLE_BITS - 1;
   localparam int STEP_BITS     = $clog2(SUM_BITS + 1);
   localparam int REQ_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((SAMPLE_BITS + PEAK_BITS + 7) / 8) * 8;

   localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(64);

   typedef struct packed {
      logic                       start;
      logic signed [SUM_BITS-1:0] dividend;
      logic [CNT_BITS-1:0]        divisor;
   } div_req_type;

   typedef struct packed {
      logic                       done;
      logic signed [SUM_BITS-1:0] quotient;
   } div_rsp_type;

endpackage

/* rtl/core/moving_average_peak_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving-average peak tracker
// Windowed running mean of signed samples with a peak-of-average tracker.
// ----------------------------------------------------------------------------
// Each sample transfer on req_ yields one result transfer on rsp_: the mean
// of the last window_len samples (fewer while the window is still filling),
// truncated toward zero, and the largest non-negative mean seen since the
// last clear. req_tready drops at each sample transfer and returns in the
// cycle in which that sample's result is loaded into the output register.
// Steps: ST_UPDATE updates the running sum (the oldest sample is read out
// of the ring at the transfer edge itself), ST_START starts the divider, the
// restoring divider yields SUM_BITS (22) quotient bits, one quotient bit per
// cycle, then ST_DIVIDE takes the quotient and ST_OUTPUT loads the result.
// No new sample is taken until the last one's result is loaded. A finished
// result waits in the output register without holding up the next sample.
// Writing csr_wdata with csr_we clears the history, the running sum and the
// peak; a length of zero acts as one, a length above 64 acts as 64. Write it
// only while no sample is in flight.
// ----------------------------------------------------------------------------
module moving_average_peak_tracker (
   input  logic                                 clock,
   input  logic                                 reset,
   // sample [15:0]
   input  logic [mapt_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // average [15:0], peak_average [30:16], zero fill above
   output logic [mapt_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_we,
   input  logic [mapt_pkg::LEN_BITS-1:0]        csr_wdata
);
   import mapt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_START,
      ST_DIVIDE,
      ST_OUTPUT
   } state_type;

   state_type                     state_ff, state_in;
   logic [LEN_BITS-1:0]           len_ff, len_in;
   logic [POS_BITS-1:0]           pos_ff, pos_in;
   logic                          full_ff, full_in;
   logic signed [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [PEAK_BITS-1:0]          peak_ff, peak_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [POS_BITS-1:0]           cur_pos_ff, cur_pos_in;
   logic [CNT_BITS-1:0]           count_ff, count_in;
   logic signed [SAMPLE_BITS-1:0] avg_ff, avg_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0]      rsp_data_ff, rsp_data_in;

   // sample ring, read port registered
   logic signed [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;
   logic                          ring_we;
   logic                          ring_re;

   logic [CNT_BITS-1:0]           eff_len;
   logic [POS_BITS-1:0]           pos_sel;
   logic [CNT_BITS-1:0]           pos_inc;
   logic signed [SAMPLE_BITS-1:0] old_sample;
   logic                          req_fire;

   div_req_type                   div_req;
   div_rsp_type                   div_rsp;

   mapt_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // clamp the programmed length into 1..MAX_WINDOW
   always_comb begin
      if (len_ff == '0) begin
         eff_len = CNT_BITS'(1);
      end else if (int'(len_ff) > MAX_WINDOW) begin
         eff_len = CNT_BITS'(MAX_WINDOW);
      end else begin
         eff_len = CNT_BITS'(len_ff);
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign pos_sel    = (CNT_BITS'(pos_ff) >= eff_len) ? '0 : pos_ff;
   assign pos_inc    = CNT_BITS'(cur_pos_ff) + 1'b1;
   assign old_sample = full_ff ? rd_data_ff : '0;
   assign ring_re    = req_fire;
   assign ring_we    = (state_ff == ST_UPDATE);

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      pos_in       = pos_ff;
      full_in      = full_ff;
      sum_in       = sum_ff;
      peak_in      = peak_ff;
      sample_in    = sample_ff;
      cur_pos_in   = cur_pos_ff;
      count_in     = count_ff;
      avg_in       = avg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      div_req      = '0;

      // drop the result once it is taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            // take the sample and start the read of the slot it overwrites
            if (req_fire) begin
               sample_in  = $signed(req_tdata[SAMPLE_BITS-1:0]);
               cur_pos_in = pos_sel;
               state_in   = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // evict the oldest sample once full, add the new one, advance
            sum_in = sum_ff - SUM_BITS'(old_sample) + SUM_BITS'(sample_ff);
            if (pos_inc >= eff_len) begin
               pos_in   = '0;
               full_in  = 1'b1;
               count_in = eff_len;
            end else begin
               pos_in   = pos_inc[POS_BITS-1:0];
               count_in = full_ff ? eff_len : pos_inc;
            end
            state_in = ST_START;
         end
         ST_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = sum_ff;
            div_req.divisor  = count_ff;
            state_in         = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               avg_in   = div_rsp.quotient[SAMPLE_BITS-1:0];
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            // hold until the output register is free, then load it
            if (!rsp_valid_ff || rsp_tready) begin
               if (avg_ff > $signed({1'b0, peak_ff})) begin
                  peak_in     = avg_ff[PEAK_BITS-1:0];
                  rsp_data_in = RSP_DATA_BITS'({avg_ff[PEAK_BITS-1:0], avg_ff});
               end else begin
                  rsp_data_in = RSP_DATA_BITS'({peak_ff, avg_ff});
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a length write clears history and peak
      if (csr_we) begin
         len_in  = csr_wdata;
         pos_in  = '0;
         full_in = 1'b0;
         sum_in  = '0;
         peak_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= LEN_RESET;
         pos_ff       <= '0;
         full_ff      <= 1'b0;
         sum_ff       <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         pos_ff       <= pos_in;
         full_ff      <= full_in;
         sum_ff       <= sum_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff   <= sample_in;
      cur_pos_ff  <= cur_pos_in;
      count_ff    <= count_in;
      avg_ff      <= avg_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring[cur_pos_ff] <= sample_ff;
      end
      if (ring_re) begin
         rd_data_ff <= ring[pos_sel];
      end
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTH
   a_pos_in_window: assert property (@(posedge clock) disable iff (reset)
      CNT_BITS'(pos_ff) < eff_len)
      else $error("write position outside the active window");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside the divide step");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("sample accepted while another is in flight");

   a_count_legal: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_START) |-> (count_ff != '0 && count_ff <= eff_len))
      else $error("divisor outside one to window length");
`endif

endmodule

/* rtl/core/mapt_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving-average peak tracker divider
// Restoring signed divide, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module mapt_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  mapt_pkg::div_req_type div_req,
   output mapt_pkg::div_rsp_type div_rsp
);
   import mapt_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 neg_ff, neg_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [SUM_BITS-1:0]  quo_ff, quo_in;
   logic [CNT_BITS-1:0]  rem_ff, rem_in;
   logic [CNT_BITS-1:0]  dvs_ff, dvs_in;
   logic [CNT_BITS:0]    trial;
   logic [CNT_BITS:0]    diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[SUM_BITS-1]};
      diff    = trial - {1'b0, dvs_ff};
      if (div_req.start) begin
         // load the magnitude, keep the sign for the end
         busy_in = 1'b1;
         neg_in  = div_req.dividend[SUM_BITS-1];
         quo_in  = div_req.dividend[SUM_BITS-1] ? SUM_BITS'(-div_req.dividend)
                                                : SUM_BITS'(div_req.dividend);
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         step_in = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[CNT_BITS-1:0];
            quo_in = {quo_ff[SUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[CNT_BITS-1:0];
            quo_in = {quo_ff[SUM_BITS-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_BITS'(SUM_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule
